// ----- rtl/core/dcf_pkg.sv -----
// dcf_pkg: shared constants and types for the disk contact force pipeline
// no dependencies; imported by dcf_mulq and disk_contact_force
package dcf_pkg;

  // q16.16 word and fraction
  localparam int unsigned QW   = 32;
  localparam int unsigned FRAC = 16;

  // saturating q16.16 product: result width and limit (2^61)
  localparam int unsigned MQ_W = 62;
  localparam logic [MQ_W-1:0] QLIM = 62'h2000_0000_0000_0000;

  // unit latencies
  localparam int unsigned SQRT_W   = 32;  // root bits, one per stage
  localparam int unsigned MEFF_QW  = 31;  // effective mass quotient bits
  localparam int unsigned NRM_QW   = 17;  // unit normal quotient bits
  localparam int unsigned MULQ_LAT = 2;

  // stream widths
  localparam int unsigned IN_TDATA_W  = 320;
  localparam int unsigned OUT_TDATA_W = 64;
  localparam int unsigned TUSER_W     = 2;

  // configuration port
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [QW-1:0] SPRING_RST   = 32'h0001_0000;
  localparam logic [QW-1:0] DAMPING_RST  = 32'h0000_0000;
  localparam logic [QW-1:0] FRICTION_RST = 32'h0000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPRING   = 2'd0,
    REG_DAMPING  = 2'd1,
    REG_FRICTION = 2'd2
  } dcf_reg_t;

endpackage

// ----- rtl/core/dcf_delay.sv -----
// dcf_delay: enabled shift line that aligns operands between pipeline stages
// depends on nothing
module dcf_delay #(
  parameter int unsigned W = 1,
  parameter int unsigned N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] taps [N];

  // shift one place per advancing cycle
  always_ff @(posedge clk) begin
    if (en) begin
      taps[0] <= d;
      for (int i = 1; i < N; i++) begin
        taps[i] <= taps[i-1];
      end
    end
  end

  assign q = taps[N-1];

endmodule

// ----- rtl/core/dcf_sqrt.sv -----
// dcf_sqrt: pipelined floor square root, one root bit per stage
// depends on nothing
module dcf_sqrt #(
  parameter int unsigned WR = 32
) (
  input  logic            clk,
  input  logic            en,
  input  logic [2*WR-1:0] v,
  output logic [WR-1:0]   root
);

  logic [WR+1:0]   rem_r  [WR];
  logic [WR-1:0]   root_r [WR];
  logic [2*WR-1:0] val_r  [WR];

  // one restoring digit step: returns {new root, new remainder}
  function automatic logic [2*WR+1:0] sq_step(input logic [WR+1:0] rem,
                                               input logic [WR-1:0] rt,
                                               input logic [1:0]    pair);
    logic [WR+1:0] rsh;
    logic [WR+1:0] trial;
    logic          ge;
    rsh   = {rem[WR-1:0], pair};
    trial = {rt, 2'b01};
    ge    = (rsh >= trial);
    return {{rt[WR-2:0], ge}, (ge ? rsh - trial : rsh)};
  endfunction

  // stage registers
  always_ff @(posedge clk) begin
    if (en) begin
      {root_r[0], rem_r[0]} <= sq_step('0, '0, v[2*WR-1 -: 2]);
      val_r[0] <= {v[2*WR-3:0], 2'b00};
      for (int i = 1; i < WR; i++) begin
        {root_r[i], rem_r[i]} <= sq_step(rem_r[i-1], root_r[i-1], val_r[i-1][2*WR-1 -: 2]);
        val_r[i] <= {val_r[i-1][2*WR-3:0], 2'b00};
      end
    end
  end

  assign root = root_r[WR-1];

endmodule

// ----- rtl/core/dcf_div.sv -----
// dcf_div: pipelined restoring divider, one quotient bit per stage
// depends on nothing; needs n < d * 2^WQ
module dcf_div #(
  parameter int unsigned WN = 48,
  parameter int unsigned WD = 32,
  parameter int unsigned WQ = 17
) (
  input  logic          clk,
  input  logic          en,
  input  logic [WN-1:0] n,
  input  logic [WD-1:0] d,
  output logic [WQ-1:0] q
);

  logic [WD-1:0] rem_r [WQ];
  logic [WQ-1:0] lo_r  [WQ];
  logic [WD-1:0] d_r   [WQ];
  logic [WQ-1:0] q_r   [WQ];
  logic [WD-1:0] rem_init;

  // upper dividend bits are already below the divisor
  assign rem_init = WD'(n[WN-1:WQ]);

  // one step: returns {quotient bit, new remainder}
  function automatic logic [WD:0] dv_step(input logic [WD-1:0] rem,
                                          input logic          nb,
                                          input logic [WD-1:0] dv);
    logic [WD:0] rsh;
    logic [WD:0] dsub;
    logic [WD:0] rnew;
    logic        ge;
    rsh  = {rem, nb};
    dsub = {1'b0, dv};
    ge   = (rsh >= dsub);
    rnew = ge ? (rsh - dsub) : rsh;
    return {ge, rnew[WD-1:0]};
  endfunction

  // stage registers
  always_ff @(posedge clk) begin
    if (en) begin
      {q_r[0][0], rem_r[0]} <= dv_step(rem_init, n[WQ-1], d);
      q_r[0][WQ-1:1] <= '0;
      lo_r[0] <= {n[WQ-2:0], 1'b0};
      d_r[0]  <= d;
      for (int i = 1; i < WQ; i++) begin
        {q_r[i][0], rem_r[i]} <= dv_step(rem_r[i-1], lo_r[i-1][WQ-1], d_r[i-1]);
        q_r[i][WQ-1:1] <= q_r[i-1][WQ-2:0];
        lo_r[i] <= {lo_r[i-1][WQ-2:0], 1'b0};
        d_r[i]  <= d_r[i-1];
      end
    end
  end

  assign q = q_r[WQ-1];

endmodule

// ----- rtl/core/dcf_mulq.sv -----
// dcf_mulq: two-stage q16.16 product, truncated and saturated to 2^61
// depends on dcf_pkg; partial products stay within 32 by 32 bits
module dcf_mulq import dcf_pkg::*; #(
  parameter int unsigned WA = 32,
  parameter int unsigned WB = 32
) (
  input  logic            clk,
  input  logic            en,
  input  logic [WA-1:0]   a,
  input  logic [WB-1:0]   b,
  output logic [MQ_W-1:0] y
);

  localparam int unsigned HA = (WA + 1) / 2;
  localparam int unsigned HB = (WB + 1) / 2;
  localparam int unsigned WP = WA + WB;
  localparam int unsigned WR = WP - FRAC;
  // compare width covers both the shifted product and the limit
  localparam int unsigned WC = (WR > MQ_W) ? WR : MQ_W;

  logic [HA+HB-1:0]        p00;
  logic [HA+WB-HB-1:0]     p01;
  logic [WA-HA+HB-1:0]     p10;
  logic [WA-HA+WB-HB-1:0]  p11;
  logic [WP-1:0]           full;
  logic [WR-1:0]           shr;
  logic [WC-1:0]           shr_c;

  // partial products
  always_ff @(posedge clk) begin
    if (en) begin
      p00 <= a[HA-1:0]  * b[HB-1:0];
      p01 <= a[HA-1:0]  * b[WB-1:HB];
      p10 <= a[WA-1:HA] * b[HB-1:0];
      p11 <= a[WA-1:HA] * b[WB-1:HB];
    end
  end

  // sum, drop fraction, saturate
  assign full  = WP'(p00) + (WP'(p01) << HB) + (WP'(p10) << HA) + (WP'(p11) << (HA + HB));
  assign shr   = full[WP-1:FRAC];
  assign shr_c = WC'(shr);

  always_ff @(posedge clk) begin
    if (en) begin
      y <= (shr_c > WC'(QLIM)) ? QLIM : shr_c[MQ_W-1:0];
    end
  end

endmodule

// ----- rtl/core/disk_contact_force.sv -----
// disk_contact_force: top level of the disk contact test and force pipeline
// depends on dcf_pkg, dcf_delay, dcf_sqrt, dcf_div and dcf_mulq
//
// usage
//   s_* carries one candidate contact per request; m_* returns one result per
//   request in the same order. cfg_* writes the three gain registers (index 0
//   spring, 1 damping, 2 friction, others ignored); cfg_ready is always high
//   and writes belong to idle periods.
//   one request is taken every cycle while the output is not stalled. The
//   depth is set by the 32-stage square root, the 17-stage normal divider
//   and the chain of two-stage saturating multipliers.
//   reset empties the pipeline and loads spring 1.0, damping 0, friction 0.
//   when m_tready is low with a result waiting, the whole pipeline holds and
//   s_tready drops in the same cycle; nothing is lost or repeated.
//   non-overlapping or same-object pairs return all zero; ghost pairs and
//   coincident centres that overlap return collided only.
module disk_contact_force import dcf_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // pos_i_x, pos_i_y, pos_j_x, pos_j_y, radius_i, radius_j,
  // rel_vel_x, rel_vel_y, mass_i, mass_j, zero pad
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // same_object, any_ghost
  input  logic [TUSER_W-1:0]     s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // force_x, force_y
  output logic [OUT_TDATA_W-1:0] m_tdata,
  // collided, force_valid
  output logic [TUSER_W-1:0]     m_tuser,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [QW-1:0]          cfg_data
);

  // stage numbers, stage 1 is the input register
  localparam int unsigned ST_DD   = 3;
  localparam int unsigned ST_D    = ST_DD + SQRT_W;
  localparam int unsigned ST_MEFF = 2 + MEFF_QW;
  localparam int unsigned ST_KR   = ST_MEFF + MULQ_LAT;
  localparam int unsigned ST_OV   = ST_D + 1;
  localparam int unsigned ST_T1   = ST_OV + MULQ_LAT;
  localparam int unsigned ST_N    = ST_D + NRM_QW;
  localparam int unsigned ST_NS   = ST_N + 1;
  localparam int unsigned ST_PR   = ST_NS + 1;
  localparam int unsigned ST_DOT  = ST_PR + 1;
  localparam int unsigned ST_DD2  = ST_DOT + 1;
  localparam int unsigned ST_B    = ST_DD2 + MULQ_LAT;
  localparam int unsigned ST_MAG  = ST_B + 1;
  localparam int unsigned ST_AMAG = ST_MAG + 1;
  localparam int unsigned ST_FM   = ST_AMAG + MULQ_LAT;
  localparam int unsigned ST_FT   = ST_FM + MULQ_LAT;
  localparam int unsigned LAT     = ST_FT + 1;

  logic [QW-1:0]  spring_gain;
  logic [QW-1:0]  damping_gain;
  logic [QW-1:0]  friction_coeff;
  logic           en;
  logic [LAT-1:0] vld;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      spring_gain    <= SPRING_RST;
      damping_gain   <= DAMPING_RST;
      friction_coeff <= FRICTION_RST;
    end else if (cfg_valid) begin
      case (dcf_reg_t'(cfg_index))
        REG_SPRING:   spring_gain    <= cfg_data;
        REG_DAMPING:  damping_gain   <= cfg_data;
        REG_FRICTION: friction_coeff <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline advance and valid chain
  assign en       = !vld[LAT-1] || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end

  // input fields
  logic signed [31:0] pix, piy, pjx, pjy, vxi, vyi;
  logic [30:0]        ri, rj, mi, mj;
  logic signed [32:0] rxi, ryi;

  assign pix = s_tdata[31:0];
  assign piy = s_tdata[63:32];
  assign pjx = s_tdata[95:64];
  assign pjy = s_tdata[127:96];
  assign ri  = s_tdata[158:128];
  assign rj  = s_tdata[189:159];
  assign vxi = s_tdata[221:190];
  assign vyi = s_tdata[253:222];
  assign mi  = s_tdata[284:254];
  assign mj  = s_tdata[315:285];
  assign rxi = {pjx[31], pjx} - {pix[31], pix};
  assign ryi = {pjy[31], pjy} - {piy[31], piy};

  // stage 1: centre offsets and radius sum
  logic [32:0] ax1, ay1;
  logic        sgx1, sgy1, same1, ghost1;
  logic [31:0] rc1, vx1, vy1;
  logic [30:0] mi1, mj1;

  always_ff @(posedge clk) begin
    if (en) begin
      ax1    <= rxi[32] ? -rxi : rxi;
      ay1    <= ryi[32] ? -ryi : ryi;
      sgx1   <= rxi[32];
      sgy1   <= ryi[32];
      rc1    <= {1'b0, ri} + {1'b0, rj};
      vx1    <= vxi;
      vy1    <= vyi;
      mi1    <= mi;
      mj1    <= mj;
      same1  <= s_tuser[0];
      ghost1 <= s_tuser[1];
    end
  end

  // stage 2: squares and mass product
  logic [63:0] a2_2, b2_2, rc2_2;
  logic [31:0] ax2, ay2, sm2;
  logic [61:0] pm2;
  logic        aok2, smnz2, same2, ghost2;

  always_ff @(posedge clk) begin
    if (en) begin
      aok2   <= (ax1 < {1'b0, rc1}) && (ay1 < {1'b0, rc1});
      a2_2   <= ax1[31:0] * ax1[31:0];
      b2_2   <= ay1[31:0] * ay1[31:0];
      rc2_2  <= rc1 * rc1;
      ax2    <= ax1[31:0];
      ay2    <= ay1[31:0];
      pm2    <= mi1 * mj1;
      sm2    <= {1'b0, mi1} + {1'b0, mj1};
      smnz2  <= |{mi1, mj1};
      same2  <= same1;
      ghost2 <= ghost1;
    end
  end

  // stage 3: overlap test and result flags
  logic [64:0] ss;
  logic        ovl;
  logic [63:0] dd3;
  logic        col3, fv3;

  assign ss  = {1'b0, a2_2} + {1'b0, b2_2};
  assign ovl = aok2 && (ss < {1'b0, rc2_2});

  always_ff @(posedge clk) begin
    if (en) begin
      dd3  <= ss[63:0];
      col3 <= ovl && !same2;
      fv3  <= ovl && !same2 && !ghost2 && (ss != '0);
    end
  end

  // distance
  logic [31:0] cdist;

  dcf_sqrt #(.WR(SQRT_W)) u_sqrt (
    .clk(clk), .en(en), .v(dd3), .root(cdist)
  );

  // effective mass and gains
  logic [MEFF_QW-1:0] meff_q, meff;
  logic               smnz_d;
  logic [MQ_W-1:0]    krm, kdm;

  dcf_div #(.WN(62), .WD(32), .WQ(MEFF_QW)) u_meff (
    .clk(clk), .en(en), .n(pm2), .d(sm2), .q(meff_q)
  );
  dcf_delay #(.W(1), .N(MEFF_QW)) u_d_smnz (
    .clk(clk), .en(en), .d(smnz2), .q(smnz_d)
  );

  assign meff = smnz_d ? meff_q : '0;

  dcf_mulq #(.WA(MEFF_QW), .WB(QW)) u_mul_kr (
    .clk(clk), .en(en), .a(meff), .b(spring_gain), .y(krm)
  );
  dcf_mulq #(.WA(MEFF_QW), .WB(QW)) u_mul_kd (
    .clk(clk), .en(en), .a(meff), .b(damping_gain), .y(kdm)
  );

  // overlap depth and spring term
  logic [31:0]     rc_d, ov36;
  logic [46:0]     kr36;
  logic [47:0]     kd_d;
  logic [MQ_W-1:0] t1, t1b;

  dcf_delay #(.W(32), .N(ST_D - 1)) u_d_rc (
    .clk(clk), .en(en), .d(rc1), .q(rc_d)
  );
  dcf_delay #(.W(47), .N(ST_OV - ST_KR)) u_d_kr (
    .clk(clk), .en(en), .d(krm[46:0]), .q(kr36)
  );
  dcf_delay #(.W(48), .N(ST_DD2 - ST_KR)) u_d_kd (
    .clk(clk), .en(en), .d({kdm[46:0], 1'b0}), .q(kd_d)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      ov36 <= rc_d - cdist;
    end
  end

  dcf_mulq #(.WA(47), .WB(32)) u_mul_t1 (
    .clk(clk), .en(en), .a(kr36), .b(ov36), .y(t1)
  );
  dcf_delay #(.W(MQ_W), .N(ST_B - ST_T1)) u_d_t1 (
    .clk(clk), .en(en), .d(t1), .q(t1b)
  );

  // unit normal magnitudes
  logic [31:0]        axd, ayd;
  logic [NRM_QW-1:0]  nxa, nya;

  dcf_delay #(.W(64), .N(ST_D - 2)) u_d_axy (
    .clk(clk), .en(en), .d({ay2, ax2}), .q({ayd, axd})
  );
  dcf_div #(.WN(48), .WD(32), .WQ(NRM_QW)) u_div_nx (
    .clk(clk), .en(en), .n({axd, 16'b0}), .d(cdist), .q(nxa)
  );
  dcf_div #(.WN(48), .WD(32), .WQ(NRM_QW)) u_div_ny (
    .clk(clk), .en(en), .n({ayd, 16'b0}), .d(cdist), .q(nya)
  );

  // signed normal
  logic               sgx_d, sgy_d;
  logic signed [31:0] vxd, vyd;
  logic signed [17:0] nx53, ny53, nx_t, ny_t;
  logic               nxneg53, nyneg53;

  dcf_delay #(.W(2), .N(ST_N - 1)) u_d_sg (
    .clk(clk), .en(en), .d({sgy1, sgx1}), .q({sgy_d, sgx_d})
  );
  dcf_delay #(.W(64), .N(ST_NS - 1)) u_d_v (
    .clk(clk), .en(en), .d({vy1, vx1}), .q({vyd, vxd})
  );

  always_ff @(posedge clk) begin
    if (en) begin
      nx53    <= sgx_d ? -{1'b0, nxa} : {1'b0, nxa};
      ny53    <= sgy_d ? -{1'b0, nya} : {1'b0, nya};
      nxneg53 <= sgx_d && (nxa != '0);
      nyneg53 <= sgy_d && (nya != '0);
    end
  end

  // normal and tangent dot products
  logic signed [49:0] pxx, pyy, pyx, pxy;
  logic signed [50:0] dn, dt;

  always_ff @(posedge clk) begin
    if (en) begin
      pxx <= nx53 * vxd;
      pyy <= ny53 * vyd;
      pyx <= ny53 * vxd;
      pxy <= nx53 * vyd;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dn <= {pxx[49], pxx} + {pyy[49], pyy};
      dt <= {pyx[49], pyx} - {pxy[49], pxy};
    end
  end

  dcf_delay #(.W(36), .N(ST_DOT - ST_NS)) u_d_n (
    .clk(clk), .en(en), .d({ny53, nx53}), .q({ny_t, nx_t})
  );

  // normal speed and tangent orientation
  logic [50:0] dn_abs;
  logic [32:0] adot;
  logic        dneg56, flip, txneg56, tyneg56;

  assign dn_abs = dn[50] ? -dn : dn;
  assign flip   = !dt[50] && (dt != '0);

  always_ff @(posedge clk) begin
    if (en) begin
      adot    <= dn_abs[48:16];
      dneg56  <= dn[50];
      txneg56 <= flip ? (!ny_t[17] && (ny_t != '0)) : ny_t[17];
      tyneg56 <= flip ? nx_t[17] : (!nx_t[17] && (nx_t != '0));
    end
  end

  // damping term and normal magnitude
  logic [MQ_W-1:0]    bm;
  logic               dneg_b;
  logic signed [63:0] mag;
  logic [62:0]        amag;
  logic               magneg60;

  dcf_mulq #(.WA(48), .WB(33)) u_mul_b (
    .clk(clk), .en(en), .a(kd_d), .b(adot), .y(bm)
  );
  dcf_delay #(.W(1), .N(ST_B - ST_DD2)) u_d_dneg (
    .clk(clk), .en(en), .d(dneg56), .q(dneg_b)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      mag <= dneg_b ? ({2'b0, bm} - {2'b0, t1b}) : (-{2'b0, t1b} - {2'b0, bm});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      amag     <= mag[63] ? 63'(-mag) : mag[62:0];
      magneg60 <= mag[63];
    end
  end

  // friction magnitude and normal force components
  logic [NRM_QW-1:0] nxa_m, nya_m, nxa_f, nya_f;
  logic [MQ_W-1:0]   fm, pnx, pny, pnx_d, pny_d, qtx, qty;

  dcf_delay #(.W(2*NRM_QW), .N(ST_AMAG - ST_N)) u_d_na (
    .clk(clk), .en(en), .d({nya, nxa}), .q({nya_m, nxa_m})
  );
  dcf_delay #(.W(2*NRM_QW), .N(ST_FM - ST_AMAG)) u_d_nf (
    .clk(clk), .en(en), .d({nya_m, nxa_m}), .q({nya_f, nxa_f})
  );

  dcf_mulq #(.WA(QW), .WB(63)) u_mul_fm (
    .clk(clk), .en(en), .a(friction_coeff), .b(amag), .y(fm)
  );
  dcf_mulq #(.WA(63), .WB(NRM_QW)) u_mul_nx (
    .clk(clk), .en(en), .a(amag), .b(nxa_m), .y(pnx)
  );
  dcf_mulq #(.WA(63), .WB(NRM_QW)) u_mul_ny (
    .clk(clk), .en(en), .a(amag), .b(nya_m), .y(pny)
  );

  // tangential force components, |tx| = |ny| and |ty| = |nx|
  dcf_mulq #(.WA(MQ_W), .WB(NRM_QW)) u_mul_tx (
    .clk(clk), .en(en), .a(fm), .b(nya_f), .y(qtx)
  );
  dcf_mulq #(.WA(MQ_W), .WB(NRM_QW)) u_mul_ty (
    .clk(clk), .en(en), .a(fm), .b(nxa_f), .y(qty)
  );
  dcf_delay #(.W(2*MQ_W), .N(ST_FT - ST_FM)) u_d_pn (
    .clk(clk), .en(en), .d({pny, pnx}), .q({pny_d, pnx_d})
  );

  // signs and flags aligned to the last stage
  logic nxneg_f, nyneg_f, txneg_f, tyneg_f, magneg_f, col_f, fv_f;

  dcf_delay #(.W(2), .N(ST_FT - ST_NS)) u_d_nneg (
    .clk(clk), .en(en), .d({nyneg53, nxneg53}), .q({nyneg_f, nxneg_f})
  );
  dcf_delay #(.W(2), .N(ST_FT - ST_DD2)) u_d_tneg (
    .clk(clk), .en(en), .d({tyneg56, txneg56}), .q({tyneg_f, txneg_f})
  );
  dcf_delay #(.W(1), .N(ST_FT - ST_AMAG)) u_d_mneg (
    .clk(clk), .en(en), .d(magneg60), .q(magneg_f)
  );
  dcf_delay #(.W(2), .N(ST_FT - ST_DD)) u_d_flags (
    .clk(clk), .en(en), .d({fv3, col3}), .q({fv_f, col_f})
  );

  // saturate to the signed 32-bit range
  function automatic logic [31:0] sat32(input logic [63:0] x);
    if (!x[63] && (x[62:31] != '0)) return 32'h7FFF_FFFF;
    if (x[63] && (x[62:31] != '1)) return 32'h8000_0000;
    return x[31:0];
  endfunction

  // component sums
  logic [63:0] sxn, sxt, syn, syt, fx, fy;

  assign sxn = (magneg_f ^ nxneg_f) ? -{2'b0, pnx_d} : {2'b0, pnx_d};
  assign syn = (magneg_f ^ nyneg_f) ? -{2'b0, pny_d} : {2'b0, pny_d};
  assign sxt = txneg_f ? -{2'b0, qtx} : {2'b0, qtx};
  assign syt = tyneg_f ? -{2'b0, qty} : {2'b0, qty};
  assign fx  = sxn + sxt;
  assign fy  = syn + syt;

  // output register
  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= fv_f ? {sat32(fy), sat32(fx)} : '0;
      m_tuser <= {fv_f, col_f};
    end
  end

`ifndef SYNTHESIS
  // a force is only ever reported for a collision
  a_fv_needs_col: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser[0] || !m_tuser[1]))
    else $error("force_valid without collided");

  // results without a force carry zero force
  a_zero_force: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[1]) |-> (m_tdata == '0))
    else $error("nonzero force on a result without force");

  // a stalled output blocks new requests
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !s_tready)
    else $error("request taken while output stalled");

  // a stalled result stays in place
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result changed");
`endif

endmodule

// ----- tb/sv/tb.sv -----
// tb: self-checking testbench for disk_contact_force
// depends on dcf_pkg and the disk_contact_force rtl; predicts each contact
// result in software and compares it field by field in request order
`timescale 1ns / 100ps

module tb;
  import dcf_pkg::*;

  typedef struct packed {
    logic        same_object;
    logic        any_ghost;
    logic [30:0] mass_j;
    logic [30:0] mass_i;
    logic [31:0] rel_vel_y;
    logic [31:0] rel_vel_x;
    logic [30:0] radius_j;
    logic [30:0] radius_i;
    logic [31:0] pos_j_y;
    logic [31:0] pos_j_x;
    logic [31:0] pos_i_y;
    logic [31:0] pos_i_x;
  } contact_t;

  typedef struct packed {
    logic        collided;
    logic        force_valid;
    logic [31:0] force_x;
    logic [31:0] force_y;
  } contact_res_t;

  localparam longint unsigned LIM61 = 64'd1 << 61;
  localparam int LATENCY = 65;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_TDATA_W-1:0] s_tdata = '0;
  logic [TUSER_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [TUSER_W-1:0] m_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [QW-1:0] cfg_data = '0;

  disk_contact_force dut (.*);

  always #1 clk = ~clk;

  // gains held by the predictor
  longint unsigned k_spring = 64'd65536, k_damp = 0, k_fric = 0;

  contact_t     pending_contacts[$];
  contact_res_t expected_results[$];
  int  send_idle_pct = 0, recv_stall_pct = 0;
  bit  hold_send = 1'b0;
  int  errors = 0;

  // floor(a*b/2^16) clipped to 2^61
  function automatic longint unsigned qmul(longint unsigned a, longint unsigned b);
    logic [127:0] p;
    p = ({64'd0, a} * {64'd0, b}) >> 16;
    if (p > LIM61) return LIM61;
    return p[63:0];
  endfunction

  function automatic longint uabs(longint x);
    return x < 0 ? -x : x;
  endfunction

  function automatic longint sqmul(longint a, longint b);
    longint m;
    m = longint'(qmul(uabs(a), uabs(b)));
    return ((a < 0) != (b < 0)) ? -m : m;
  endfunction

  function automatic logic [31:0] clip32(longint x);
    if (x > 64'sd2147483647) x = 64'sd2147483647;
    if (x < -64'sd2147483648) x = -64'sd2147483648;
    return x[31:0];
  endfunction

  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic contact_res_t contact_force(contact_t c);
    contact_res_t res;
    longint rx, ry, vx, vy, nx, ny, tx, ty, ddot, mag, bterm;
    longint unsigned ax, ay, rc, dd, a2, s, d, ov, msum, meff, kr, kd, fm;
    res = '0;
    rx = longint'(signed'(c.pos_j_x)) - longint'(signed'(c.pos_i_x));
    ry = longint'(signed'(c.pos_j_y)) - longint'(signed'(c.pos_i_y));
    vx = longint'(signed'(c.rel_vel_x));
    vy = longint'(signed'(c.rel_vel_y));
    ax = uabs(rx);
    ay = uabs(ry);
    rc = longint'(c.radius_i) + longint'(c.radius_j);
    // strict overlap test; distances beyond the sum rule out overflow
    if (!(ax < rc && ay < rc)) return res;
    a2 = ax * ax;
    s = a2 + ay * ay;
    if (!(s >= a2 && s < rc * rc)) return res;
    if (c.same_object) return res;
    dd = s;
    res.collided = 1'b1;
    if (c.any_ghost || dd == 0) return res;
    d = root64(dd);
    ov = rc - d;
    msum = longint'(c.mass_i) + longint'(c.mass_j);
    meff = msum != 0 ? (longint'(c.mass_i) * longint'(c.mass_j)) / msum : 0;
    kr = qmul(meff, k_spring);
    kd = qmul(meff, k_damp) * 2;
    if (kd > LIM61) kd = LIM61;
    nx = longint'((ax << 16) / d);
    if (rx < 0) nx = -nx;
    ny = longint'((ay << 16) / d);
    if (ry < 0) ny = -ny;
    ddot = nx * vx + ny * vy;
    ddot = ddot < 0 ? -(longint'(uabs(ddot) >> 16)) : longint'(uabs(ddot) >> 16);
    tx = ny;
    ty = -nx;
    // tangent turned against the relative velocity
    if (tx * vx + ty * vy > 0) begin
      tx = -tx;
      ty = -ty;
    end
    bterm = longint'(qmul(kd, uabs(ddot)));
    if (ddot < 0) bterm = -bterm;
    mag = -longint'(qmul(kr, ov)) - bterm;
    fm = qmul(k_fric, uabs(mag));
    res.force_valid = 1'b1;
    res.force_x = clip32(sqmul(mag, nx) + sqmul(longint'(fm), tx));
    res.force_y = clip32(sqmul(mag, ny) + sqmul(longint'(fm), ty));
    return res;
  endfunction

  // request driver
  always @(posedge clk) begin
    contact_t c;
    if (!rst) begin
      if (!s_tvalid || s_tready) begin
        if (pending_contacts.size() != 0 && !hold_send &&
            $urandom_range(99) >= send_idle_pct) begin
          c = pending_contacts.pop_front();
          expected_results.push_back(contact_force(c));
          s_tvalid <= 1'b1;
          s_tdata  <= {4'b0000, c.mass_j, c.mass_i, c.rel_vel_y, c.rel_vel_x, c.radius_j,
                       c.radius_i, c.pos_j_y, c.pos_j_x, c.pos_i_y, c.pos_i_x};
          s_tuser  <= {c.any_ghost, c.same_object};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result monitor
  always @(posedge clk) begin
    contact_res_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        $error("result with nothing expected");
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (m_tuser[0] !== exp_r.collided) begin
          $error("collided exp %0d got %0d", exp_r.collided, m_tuser[0]);
          errors++;
        end
        if (m_tuser[1] !== exp_r.force_valid) begin
          $error("force_valid exp %0d got %0d", exp_r.force_valid, m_tuser[1]);
          errors++;
        end
        if (m_tdata[31:0] !== exp_r.force_x) begin
          $error("force_x exp %h got %h", exp_r.force_x, m_tdata[31:0]);
          errors++;
        end
        if (m_tdata[63:32] !== exp_r.force_y) begin
          $error("force_y exp %h got %h", exp_r.force_y, m_tdata[63:32]);
          errors++;
        end
      end
    end
  end

  function automatic logic [31:0] rnd_coord(int spread);
    return $urandom_range(spread) - spread / 2;
  endfunction

  // random contact: mostly near pairs so that forces are exercised
  function automatic contact_t rnd_contact();
    contact_t c;
    int mode;
    mode = $urandom_range(9);
    c.pos_i_x = $urandom();
    c.pos_i_y = $urandom();
    c.rel_vel_x = $urandom();
    c.rel_vel_y = $urandom();
    c.mass_i = $urandom_range(9) == 0 ? 31'($urandom()) : 31'($urandom_range(1 << 20, 1));
    c.mass_j = $urandom_range(9) == 0 ? 31'($urandom()) : 31'($urandom_range(1 << 20, 1));
    if (c.mass_i == 0) c.mass_i = 31'd1;
    if (c.mass_j == 0) c.mass_j = 31'd1;
    c.same_object = ($urandom_range(9) == 0);
    c.any_ghost = ($urandom_range(9) == 0);
    if (mode < 8) begin
      c.radius_i = 31'($urandom_range(1 << 18));
      c.radius_j = 31'($urandom_range(1 << 18));
      c.pos_i_x = $urandom_range(1 << 28) - (1 << 27);
      c.pos_i_y = $urandom_range(1 << 28) - (1 << 27);
      c.pos_j_x = c.pos_i_x + rnd_coord(1 << 19);
      c.pos_j_y = c.pos_i_y + rnd_coord(1 << 19);
      if (mode < 4) begin
        c.rel_vel_x = rnd_coord(1 << 20);
        c.rel_vel_y = rnd_coord(1 << 20);
      end
    end else begin
      c.radius_i = 31'($urandom());
      c.radius_j = 31'($urandom());
      c.pos_j_x = $urandom();
      c.pos_j_y = $urandom();
    end
    return c;
  endfunction

  task automatic wait_drained();
    while (pending_contacts.size() != 0 || expected_results.size() != 0 || s_tvalid)
      @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic wait_drained_results();
    while (expected_results.size() != 0 || s_tvalid) @(posedge clk);
  endtask

  task automatic write_gain(dcf_reg_t idx, logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_SPRING:   k_spring = val;
      REG_DAMPING:  k_damp = val;
      REG_FRICTION: k_fric = val;
      default: ;
    endcase
  endtask

  task automatic random_phase(int n, int idle, int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    repeat (n) pending_contacts.push_back(rnd_contact());
    wait_drained();
  endtask

  initial begin
    contact_t c;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: reset gains, extremes and each special case
    c = '0;
    c.mass_i = 31'h10000; c.mass_j = 31'h10000;
    c.radius_i = 31'h10000; c.radius_j = 31'h10000;
    c.pos_j_x = 32'h8000;
    c.rel_vel_y = 32'h10000;
    pending_contacts.push_back(c);                 // plain overlap
    c.same_object = 1'b1; pending_contacts.push_back(c);
    c.same_object = 1'b0; c.any_ghost = 1'b1; pending_contacts.push_back(c);
    c.any_ghost = 1'b0; c.pos_j_x = 0; pending_contacts.push_back(c);  // coincident
    c.radius_i = 31'd0; c.radius_j = 31'd0; pending_contacts.push_back(c);  // zero radii
    c.radius_i = 31'h10000; c.radius_j = 31'h10000;
    c.pos_j_x = 32'h20000; pending_contacts.push_back(c);           // touching only
    c = '1;
    c.same_object = 1'b0; c.any_ghost = 1'b0;
    pending_contacts.push_back(c);                 // all ones
    c.pos_i_x = 32'h8000_0000; c.pos_i_y = 32'h8000_0000;
    c.pos_j_x = 32'h7fff_ffff; c.pos_j_y = 32'h7fff_ffff;
    c.rel_vel_x = 32'h8000_0000;
    pending_contacts.push_back(c);                 // widest separation
    c.pos_j_x = 32'h8000_0001; c.pos_j_y = 32'h8000_0000;
    pending_contacts.push_back(c);                 // big masses and radii
    c.mass_i = 31'd1; c.mass_j = 31'd1; c.rel_vel_y = 32'h7fff_ffff;
    pending_contacts.push_back(c);
    wait_drained();

    write_gain(REG_SPRING, 32'hffff_ffff);
    write_gain(REG_DAMPING, 32'hffff_ffff);
    write_gain(REG_FRICTION, 32'hffff_ffff);
    random_phase(150, 0, 0);

    write_gain(REG_SPRING, 32'h0);
    write_gain(REG_DAMPING, 32'h0);
    write_gain(REG_FRICTION, 32'h0);
    random_phase(150, 51, 0);

    write_gain(REG_SPRING, 32'h0002_0000);
    write_gain(REG_DAMPING, 32'h0000_8000);
    write_gain(REG_FRICTION, 32'h0000_4000);
    random_phase(150, 0, 51);

    // hold the sender until every result is back
    hold_send = 1'b1;
    repeat (80) pending_contacts.push_back(rnd_contact());
    wait_drained_results();
    hold_send = 1'b0;
    random_phase(150, 26, 26);

    write_gain(REG_SPRING, $urandom());
    write_gain(REG_DAMPING, $urandom());
    write_gain(REG_FRICTION, $urandom());
    random_phase(250, 0, 0);

    write_gain(REG_SPRING, $urandom_range(1 << 20));
    write_gain(REG_DAMPING, $urandom_range(1 << 18));
    write_gain(REG_FRICTION, $urandom_range(1 << 17));
    random_phase(220, 26, 26);

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // timeout
  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/dcf_pkg.sv
rtl/core/dcf_delay.sv
rtl/core/dcf_sqrt.sv
rtl/core/dcf_div.sv
rtl/core/dcf_mulq.sv
rtl/core/disk_contact_force.sv
tb/sv/tb.sv
